// File: sv/assert_macros.svh
// Assertion macros for the escape frame decoder.
// Clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define EFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define EFD_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: sv/efd_pkg.sv
// Shared types and codes of the escape frame decoder.
// No dependencies.
`default_nettype none

package efd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int REG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [LIMIT_W-1:0]   t_limit;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Result status codes
    localparam t_status ST_DATA     = 3'd0;
    localparam t_status ST_START    = 3'd1;
    localparam t_status ST_END      = 3'd2;
    localparam t_status ST_ALARM    = 3'd3;
    localparam t_status ST_BAD_ESC  = 3'd4;
    localparam t_status ST_OVERFLOW = 3'd5;

    // Configuration register indexes
    localparam t_reg_idx REG_ESCAPE = 3'd0;
    localparam t_reg_idx REG_START  = 3'd1;
    localparam t_reg_idx REG_END    = 3'd2;
    localparam t_reg_idx REG_ALARM  = 3'd3;
    localparam t_reg_idx REG_LIMIT  = 3'd4;

    // Reset values of the configuration registers
    localparam t_byte  RST_ESCAPE = 8'd27;
    localparam t_byte  RST_START  = 8'd2;
    localparam t_byte  RST_END    = 8'd3;
    localparam t_byte  RST_ALARM  = 8'd7;
    localparam t_limit RST_LIMIT  = 11'd1024;

    typedef struct packed {
        t_byte esc_code;
        t_byte sof_code;
        t_byte eof_code;
        t_byte alarm_code;
    } t_markers;

    // Decision for one byte, before the fill limit is applied
    typedef struct packed {
        logic    store;
        t_byte   data;
        t_status status;
        logic    pending_next;
        logic    clear_fill;
    } t_action;

endpackage

`default_nettype wire

// File: sv/efd_cfg_regs.sv
// Configuration registers: marker bytes and frame limit.
// Depends on efd_pkg.
`default_nettype none

module efd_cfg_regs
    import efd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_wr_en,
    input  wire t_reg_idx i_wr_index,
    input  wire t_limit   i_wr_data,
    output t_markers      o_markers,
    output t_limit        o_frame_limit
);

    t_markers r_markers;
    t_limit   r_frame_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markers.esc_code   <= RST_ESCAPE;
            r_markers.sof_code   <= RST_START;
            r_markers.eof_code   <= RST_END;
            r_markers.alarm_code <= RST_ALARM;
            r_frame_limit        <= RST_LIMIT;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_ESCAPE: r_markers.esc_code   <= i_wr_data[BYTE_W-1:0];
                REG_START:  r_markers.sof_code   <= i_wr_data[BYTE_W-1:0];
                REG_END:    r_markers.eof_code   <= i_wr_data[BYTE_W-1:0];
                REG_ALARM:  r_markers.alarm_code <= i_wr_data[BYTE_W-1:0];
                REG_LIMIT:  r_frame_limit        <= i_wr_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_markers     = r_markers;
    assign o_frame_limit = r_frame_limit;

endmodule

`default_nettype wire

// File: sv/efd_classify.sv
// Combinational byte classifier: compares a line byte with the markers.
// Depends on efd_pkg.
`default_nettype none

module efd_classify
    import efd_pkg::*;
(
    input  wire t_byte    i_byte,
    input  wire logic     i_pending,
    input  wire t_markers i_markers,
    output t_action       o_action
);

    logic inv_hit;

    assign inv_hit = (i_byte == ~i_markers.esc_code) || (i_byte == ~i_markers.sof_code)
                  || (i_byte == ~i_markers.eof_code) || (i_byte == ~i_markers.alarm_code);

    always_comb begin
        o_action.store        = 1'b0;
        o_action.data         = i_byte;
        o_action.status       = ST_DATA;
        o_action.pending_next = 1'b0;
        o_action.clear_fill   = 1'b0;
        if (i_pending) begin
            // inverted marker wins over alarm
            priority if (inv_hit) begin
                o_action.store = 1'b1;
                o_action.data  = ~i_byte;
            end else if (i_byte == i_markers.alarm_code) begin
                o_action.status       = ST_ALARM;
                o_action.pending_next = 1'b1;
            end else begin
                o_action.status = ST_BAD_ESC;
            end
        end else begin
            priority if (i_byte == i_markers.esc_code) begin
                o_action.pending_next = 1'b1;
            end else if (i_byte == i_markers.sof_code) begin
                o_action.status     = ST_START;
                o_action.clear_fill = 1'b1;
            end else if (i_byte == i_markers.eof_code) begin
                o_action.status = ST_END;
            end else if (i_byte == i_markers.alarm_code) begin
                o_action.status = ST_ALARM;
            end else begin
                o_action.store = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/escape_frame_decoder.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------------
// input     | in        | i_valid / o_stall  | i_rx_byte
// result    | out       | o_valid / i_stall  | o_status o_byte_valid o_data_byte
//           |           |                    | o_write_index
// config    | in        | i_cfg_valid/ready  | i_cfg_index i_cfg_data
//
// One byte per cycle sustained unless i_stall holds the result; input, then result register.
// The escape flag and fill counter update in the cycle a byte moves from the input
// register to the result register.
// Synchronous active-low reset clears the escape flag, fill count and valid bits.
// o_stall rises only when the input register is full and the result is held.
//
// Top level of the escape frame decoder; uses efd_pkg, efd_cfg_regs, efd_classify.
`default_nettype none
`include "assert_macros.svh"

module escape_frame_decoder
    import efd_pkg::*;
#(
    parameter int MAX_FRAME = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [BYTE_W-1:0]   i_rx_byte,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_byte_valid,
    output logic [BYTE_W-1:0]        o_data_byte,
    output logic [INDEX_W-1:0]       o_write_index,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]  i_cfg_data
);

    // The fill count can never pass the largest limit a register can hold.
    localparam int LIM_CAP = (MAX_FRAME < 2047) ? MAX_FRAME : 2047;
    localparam int FILL_W  = $clog2(LIM_CAP + 1);
    localparam t_limit LIM_CAP_L = LIMIT_W'(LIM_CAP);

    t_markers markers;
    t_limit   frame_limit;
    t_action  act;

    logic              r_in_valid;
    t_byte             r_in_byte;
    logic              r_pending;
    logic [FILL_W-1:0] r_fill;
    t_limit            fill_ext;
    logic              full;
    logic              advance;

    logic          r_out_valid;
    t_status       r_status;
    logic          r_byte_valid;
    t_byte         r_data_byte;
    logic [INDEX_W-1:0] r_write_index;

    efd_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (i_cfg_valid),
        .i_wr_index    (i_cfg_index),
        .i_wr_data     (i_cfg_data),
        .o_markers     (markers),
        .o_frame_limit (frame_limit)
    );

    efd_classify u_classify (
        .i_byte    (r_in_byte),
        .i_pending (r_pending),
        .i_markers (markers),
        .o_action  (act)
    );

    assign o_cfg_ready = 1'b1;

    assign advance = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    assign fill_ext = LIMIT_W'(r_fill);
    assign full     = (fill_ext >= frame_limit) || (fill_ext >= LIM_CAP_L);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // escape flag and fill counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_fill    <= '0;
        end else if (advance) begin
            r_pending <= act.pending_next;
            if (act.clear_fill) begin
                r_fill <= '0;
            end else if (act.store && !full) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status      <= act.status;
            r_byte_valid  <= 1'b0;
            r_data_byte   <= '0;
            r_write_index <= '0;
            if (act.store) begin
                if (full) begin
                    r_status <= ST_OVERFLOW;
                end else begin
                    r_status      <= ST_DATA;
                    r_byte_valid  <= 1'b1;
                    r_data_byte   <= act.data;
                    r_write_index <= fill_ext[INDEX_W-1:0];
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_byte_valid  = r_byte_valid;
    assign o_data_byte   = r_data_byte;
    assign o_write_index = r_write_index;

    `EFD_NEVER(a_fill_cap, fill_ext > LIM_CAP_L, "fill count above frame cap")
    `EFD_ASSERT(a_valid_data, (o_valid && o_byte_valid) |-> (o_status == ST_DATA),
        "stored byte without data status")
    `EFD_ASSERT(a_stall_src, o_stall |-> (r_in_valid && o_valid),
        "input stalled with no held result")
    `EFD_ASSERT(a_fill_step, (advance && act.store && !full) |=>
        (r_fill == $past(r_fill) + FILL_W'(1)), "fill count did not advance on store")

endmodule

`default_nettype wire
